// File: src/egdr_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the dead-reckoning core.
`default_nettype none
package egdr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int COUNT_W    = 32;
  localparam int YAW_W      = 9;
  localparam int SCALE_W    = 24;
  localparam int SPLIT_W    = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  localparam int DEG_45  = 45;
  localparam int DEG_90  = 90;
  localparam int DEG_180 = 180;
  localparam int DEG_360 = 360;

  localparam int QUARTER_ENTRIES = 91;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_ROT,
    ST_ACC,
    ST_POS
  } state_t;

  typedef struct packed {
    logic load;
    logic look;
    logic mul1;
    logic sum;
    logic mul2;
    logic rot;
    logic acc;
    logic commit;
  } cmd_t;

  // sin(k deg), k in 0..90, Taylor series in Q30, rounded half up to frac bits
  function automatic logic [31:0] quarter_sine(input int unsigned k, input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] rnd;
    longint      acc;
    int unsigned n;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rnd = (64'(acc) + (64'd1 << (29 - frac))) >> (30 - frac);
    return rnd[31:0];
  endfunction

endpackage
`default_nettype wire

// File: src/egdr_ctrl.sv
// Sequencing state machine: handshakes and per-stage datapath commands.
`default_nettype none
module egdr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output egdr_pkg::cmd_t     cmd
);

  egdr_pkg::state_t state;
  egdr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= egdr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      egdr_pkg::ST_IDLE: begin
        if (in_valid) state_next = egdr_pkg::ST_LOOK;
      end
      egdr_pkg::ST_LOOK: state_next = egdr_pkg::ST_MUL1;
      egdr_pkg::ST_MUL1: state_next = egdr_pkg::ST_SUM;
      egdr_pkg::ST_SUM:  state_next = egdr_pkg::ST_MUL2;
      egdr_pkg::ST_MUL2: state_next = egdr_pkg::ST_ROT;
      egdr_pkg::ST_ROT:  state_next = egdr_pkg::ST_ACC;
      egdr_pkg::ST_ACC:  state_next = egdr_pkg::ST_POS;
      egdr_pkg::ST_POS: begin
        if (!out_valid || out_ready) state_next = egdr_pkg::ST_IDLE;
      end
      default: state_next = egdr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      egdr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      egdr_pkg::ST_LOOK: cmd.look = 1'b1;
      egdr_pkg::ST_MUL1: cmd.mul1 = 1'b1;
      egdr_pkg::ST_SUM:  cmd.sum  = 1'b1;
      egdr_pkg::ST_MUL2: cmd.mul2 = 1'b1;
      egdr_pkg::ST_ROT:  cmd.rot  = 1'b1;
      egdr_pkg::ST_ACC:  cmd.acc  = 1'b1;
      egdr_pkg::ST_POS:  cmd.commit = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == egdr_pkg::ST_LOOK)
    else $error("accepted beat did not start the sequence");

  a_pos_holds: assert property (@(posedge clk) disable iff (rst)
    (state == egdr_pkg::ST_POS && out_valid && !out_ready) |=> state == egdr_pkg::ST_POS)
    else $error("result overwritten while output beat pending");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == egdr_pkg::ST_POS)
    else $error("output valid raised outside commit");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule
`default_nettype wire

// File: src/egdr_datapath.sv
// Datapath: yaw wrap, sine lookup, rotation multiplies, position accumulate and config registers.
`default_nettype none
module egdr_datapath #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire egdr_pkg::cmd_t                        cmd,
  input  wire logic                                  cfg_we,
  input  wire logic [egdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [egdr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic signed [egdr_pkg::COUNT_W-1:0]   right_count,
  input  wire logic signed [egdr_pkg::COUNT_W-1:0]   left_count,
  input  wire logic signed [egdr_pkg::YAW_W-1:0]     raw_yaw,
  output logic signed [egdr_pkg::COUNT_W-1:0]        pos_x,
  output logic signed [egdr_pkg::COUNT_W-1:0]        pos_y,
  output logic signed [egdr_pkg::YAW_W-1:0]          heading
);

  localparam int RomW = SINE_FRAC_BITS + 1;
  localparam int SW   = SINE_FRAC_BITS + 2;
  localparam int PW   = egdr_pkg::COUNT_W + SW;
  localparam int TW   = PW + 1;
  localparam int LoW  = egdr_pkg::SPLIT_W;
  localparam int HiW  = TW - LoW;
  localparam int LpW  = LoW + egdr_pkg::SCALE_W;
  localparam int HpW  = HiW + egdr_pkg::SCALE_W + 1;
  localparam int RW   = TW + egdr_pkg::SCALE_W + 1;
  localparam int AW   = RW + 1;
  localparam int Sh   = 16 + SINE_FRAC_BITS;

  // config and architectural state
  logic signed [egdr_pkg::YAW_W-1:0]   yaw_offset;
  logic [egdr_pkg::SCALE_W-1:0]        distance_scale;
  logic signed [egdr_pkg::COUNT_W-1:0] last_right;
  logic signed [egdr_pkg::COUNT_W-1:0] last_left;

  // stage registers
  logic signed [egdr_pkg::YAW_W-1:0]   yaw_w;
  logic signed [egdr_pkg::COUNT_W-1:0] diff_r;
  logic signed [egdr_pkg::COUNT_W-1:0] diff_l;
  logic signed [SW-1:0]                sin_v;
  logic signed [SW-1:0]                cos_v;
  logic signed [PW-1:0]                pr_s;
  logic signed [PW-1:0]                pl_c;
  logic signed [PW-1:0]                pr_c;
  logic signed [PW-1:0]                pl_s;
  logic signed [TW-1:0]                t_x;
  logic signed [TW-1:0]                t_y;
  logic [LpW-1:0]                      lo_prod_x;
  logic [LpW-1:0]                      lo_prod_y;
  logic signed [HpW-1:0]               hi_prod_x;
  logic signed [HpW-1:0]               hi_prod_y;
  logic signed [RW-1:0]                rot_x;
  logic signed [RW-1:0]                rot_y;
  logic signed [AW-1:0]                acc_x;
  logic signed [AW-1:0]                acc_y;

  // combinational
  logic signed [10:0]                  yaw_sum;
  logic signed [10:0]                  yaw_w1;
  logic signed [10:0]                  yaw_w2;
  logic signed [9:0]                   ang_raw;
  logic [8:0]                          ang_s;
  logic [9:0]                          ang_c_sum;
  logic [8:0]                          ang_c;
  logic [7:0]                          fold_s;
  logic [7:0]                          fold_c;
  logic signed [SW-1:0]                rom_s;
  logic signed [SW-1:0]                rom_c;
  logic signed [SW-1:0]                sin_next;
  logic signed [SW-1:0]                cos_next;
  logic signed [egdr_pkg::SCALE_W:0]   scale_s;
  logic signed [egdr_pkg::COUNT_W-1:0] pos_x_next;
  logic signed [egdr_pkg::COUNT_W-1:0] pos_y_next;

  logic [RomW-1:0] sine_rom [0:egdr_pkg::QUARTER_ENTRIES-1];

  for (genvar g = 0; g < egdr_pkg::QUARTER_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = RomW'(egdr_pkg::quarter_sine(unsigned'(g), SINE_FRAC_BITS));
  end

  // {negate, quarter index} for an angle in 0..359
  function automatic logic [7:0] fold(input logic [8:0] a);
    logic [8:0] q;
    logic       neg;
    if (a <= 9'(egdr_pkg::DEG_90)) begin
      q = a;
      neg = 1'b0;
    end else if (a <= 9'(egdr_pkg::DEG_180)) begin
      q = 9'(egdr_pkg::DEG_180) - a;
      neg = 1'b0;
    end else if (a <= 9'(egdr_pkg::DEG_180 + egdr_pkg::DEG_90)) begin
      q = a - 9'(egdr_pkg::DEG_180);
      neg = 1'b1;
    end else begin
      q = 9'(egdr_pkg::DEG_360) - a;
      neg = 1'b1;
    end
    return {neg, q[6:0]};
  endfunction

  always_comb begin
    yaw_sum = {{2{raw_yaw[8]}}, raw_yaw} + {{2{yaw_offset[8]}}, yaw_offset};
    yaw_w1  = (yaw_sum >= 11'(egdr_pkg::DEG_180)) ? yaw_sum - 11'(egdr_pkg::DEG_360) : yaw_sum;
    yaw_w2  = (yaw_w1 <= -11'(egdr_pkg::DEG_180)) ? yaw_w1 + 11'(egdr_pkg::DEG_360) : yaw_w1;
  end

  always_comb begin
    ang_raw   = {yaw_w[8], yaw_w} - 10'(egdr_pkg::DEG_45);
    ang_s     = ang_raw[9] ? 9'(ang_raw + 10'(egdr_pkg::DEG_360)) : ang_raw[8:0];
    ang_c_sum = {1'b0, ang_s} + 10'(egdr_pkg::DEG_90);
    ang_c     = (ang_c_sum >= 10'(egdr_pkg::DEG_360)) ?
                9'(ang_c_sum - 10'(egdr_pkg::DEG_360)) : ang_c_sum[8:0];
    fold_s    = fold(ang_s);
    fold_c    = fold(ang_c);
    rom_s     = signed'({1'b0, sine_rom[fold_s[6:0]]});
    rom_c     = signed'({1'b0, sine_rom[fold_c[6:0]]});
    sin_next  = fold_s[7] ? -rom_s : rom_s;
    cos_next  = fold_c[7] ? -rom_c : rom_c;
  end

  assign scale_s = signed'({1'b0, distance_scale});

  // truncate toward zero: floor, plus one when negative and inexact
  assign pos_x_next = acc_x[Sh+31:Sh] +
                      egdr_pkg::COUNT_W'(acc_x[AW-1] && (acc_x[Sh-1:0] != '0));
  assign pos_y_next = acc_y[Sh+31:Sh] +
                      egdr_pkg::COUNT_W'(acc_y[AW-1] && (acc_y[Sh-1:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset     <= '0;
      distance_scale <= egdr_pkg::SCALE_RESET;
      last_right     <= '0;
      last_left      <= '0;
      pos_x          <= '0;
      pos_y          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          egdr_pkg::CFG_YAW_OFFSET:     yaw_offset     <= signed'(cfg_data[8:0]);
          egdr_pkg::CFG_DISTANCE_SCALE: distance_scale <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_right <= right_count;
        last_left  <= left_count;
      end
      if (cmd.commit) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yaw_w  <= yaw_w2[8:0];
      diff_r <= right_count - last_right;
      diff_l <= left_count - last_left;
    end
    if (cmd.look) begin
      sin_v <= sin_next;
      cos_v <= cos_next;
    end
    if (cmd.mul1) begin
      pr_s <= diff_r * sin_v;
      pl_c <= diff_l * cos_v;
      pr_c <= diff_r * cos_v;
      pl_s <= diff_l * sin_v;
    end
    if (cmd.sum) begin
      t_x <= TW'(pr_s) - TW'(pl_c);
      t_y <= TW'(pr_c) + TW'(pl_s);
    end
    if (cmd.mul2) begin
      lo_prod_x <= t_x[LoW-1:0] * distance_scale;
      lo_prod_y <= t_y[LoW-1:0] * distance_scale;
      hi_prod_x <= signed'(t_x[TW-1:LoW]) * scale_s;
      hi_prod_y <= signed'(t_y[TW-1:LoW]) * scale_s;
    end
    if (cmd.rot) begin
      rot_x <= (RW'(hi_prod_x) <<< LoW) + signed'(RW'(lo_prod_x));
      rot_y <= (RW'(hi_prod_y) <<< LoW) + signed'(RW'(lo_prod_y));
    end
    if (cmd.acc) begin
      acc_x <= (AW'(pos_x) <<< Sh) + AW'(rot_x);
      acc_y <= (AW'(pos_y) <<< Sh) + AW'(rot_y);
    end
    if (cmd.commit) begin
      heading <= yaw_w;
    end
  end

endmodule
`default_nettype wire

// File: src/encoder_gyro_dead_reckoning_core.sv
// One input beat is in flight at a time: in_ready is high only in idle, and the controller's
// eight-state sequence runs idle, lookup, first multiply rank, sum, second multiply rank,
// rotate add, accumulate and commit; a pending output beat holds the commit state until
// it is taken.
// Reset: position and last counts clear to zero, yaw offset to 0, scale to 1.0 (Q8.16).
// Top level of the encoder and gyro dead-reckoning core.
`default_nettype none
module encoder_gyro_dead_reckoning_core #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [egdr_pkg::COUNT_W-1:0]   right_count,
  input  wire logic signed [egdr_pkg::COUNT_W-1:0]   left_count,
  input  wire logic signed [egdr_pkg::YAW_W-1:0]     raw_yaw,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [egdr_pkg::COUNT_W-1:0]        pos_x,
  output logic signed [egdr_pkg::COUNT_W-1:0]        pos_y,
  output logic signed [egdr_pkg::YAW_W-1:0]          heading,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [egdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [egdr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  egdr_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  egdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  egdr_datapath #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .right_count (right_count),
    .left_count  (left_count),
    .raw_yaw     (raw_yaw),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading)
  );

endmodule
`default_nettype wire
